>>> sv/lpht_pkg.sv
// Shared types and constants for the linear probing hash table.
package lpht_pkg;

    localparam int KEY_W      = 31;
    localparam int SLOT_W     = 4;
    // Home slot: reciprocal multiply, then back-multiply and subtract.
    localparam int HASH_STEPS = 2;
    localparam int HCNT_W     = $clog2(HASH_STEPS);
    localparam int ENTRY_W    = KEY_W + 1;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_END       = 3'd4
    } status_t;

    typedef struct packed
    {
        op_t              opcode;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed
    {
        status_t           status;
        logic [SLOT_W-1:0] slot_index;
    } rsp_t;

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FETCH,
        S_PROBE
    } state_t;

    typedef struct packed
    {
        logic clr;
        logic load;
        logic hash;
        logic fetch;
        logic probe;
    } dp_cmd_t;

    typedef struct packed
    {
        logic clr_done;
        logic hash_done;
        logic probe_done;
    } dp_sts_t;

endpackage

>>> sv/lpht_mod_unit.sv
// Home slot unit: key modulo table size by reciprocal multiplication, then back-multiply and subtract.
module lpht_mod_unit #(
    parameter int TABLE_SIZE = 16,
    localparam int IDX_W = $clog2(TABLE_SIZE)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       step,
    input  logic [lpht_pkg::KEY_W-1:0] key,
    output logic [IDX_W-1:0]           home,
    output logic                       last_step
);
    import lpht_pkg::*;

    localparam int SHIFT  = KEY_W + IDX_W;
    localparam int PROD_W = 2 * KEY_W + 1;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
    localparam logic [KEY_W:0]   RECIP   = RECIP_FULL[KEY_W:0];
    localparam logic [IDX_W-1:0] MOD_LOW = IDX_W'(TABLE_SIZE);

    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [KEY_W-1:0]  quo_reg;
    logic [KEY_W-1:0]  quo_next;
    logic [IDX_W-1:0]  rem_reg;
    logic [IDX_W-1:0]  rem_next;
    logic [HCNT_W-1:0] cnt_reg;
    logic [HCNT_W-1:0] cnt_next;
    logic [PROD_W-1:0] prod;
    logic [KEY_W-1:0]  quo;
    logic [IDX_W-1:0]  rem;

    // The rounded-up reciprocal gives the exact quotient for every 31-bit key.
    assign prod = PROD_W'(key_reg) * PROD_W'(RECIP);
    assign quo  = KEY_W'(prod >> SHIFT);
    // The remainder is below the table size, so the low index bits suffice.
    assign rem  = key_reg[IDX_W-1:0] - IDX_W'(quo_reg[IDX_W-1:0] * MOD_LOW);

    always_comb
    begin
        key_next = key_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            key_next = key;
            cnt_next = '0;
        end
        else if (step)
        begin
            quo_next = quo;
            rem_next = rem;
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign home      = rem_reg;
    assign last_step = (cnt_reg == HCNT_W'(HASH_STEPS - 1));

endmodule

>>> sv/lpht_datapath.sv
// Datapath: item register, slot memory, probe compare and result register.
module lpht_datapath #(
    parameter int TABLE_SIZE = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lpht_pkg::dp_cmd_t cmd,
    input  lpht_pkg::req_t    req,
    output lpht_pkg::dp_sts_t sts,
    output logic              done,
    output lpht_pkg::rsp_t    rsp
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    logic [ENTRY_W-1:0] mem [TABLE_SIZE];

    op_t              op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] clr_reg;
    logic [ENTRY_W-1:0] rdata_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             done_reg;
    logic             done_next;

    logic [IDX_W-1:0]   home;
    logic               hash_last;
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               wr_en;
    logic               slot_full;
    logic               key_hit;
    logic               at_last;
    logic               finish;
    logic               write_slot;

    lpht_mod_unit #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd.load),
        .step      (cmd.hash),
        .key       (req.key),
        .home      (home),
        .last_step (hash_last)
    );

    assign slot_full = rdata_reg[ENTRY_W-1];
    assign key_hit   = (rdata_reg[KEY_W-1:0] == key_reg);
    assign at_last   = (idx_reg == LAST_IDX);

    always_comb
    begin
        finish     = 1'b1;
        write_slot = 1'b0;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        if (!slot_full)
        begin
            if (op_reg == OP_INSERT)
            begin
                write_slot = 1'b1;
                rsp_next   = '{status: ST_INSERTED, slot_index: SLOT_W'(idx_reg)};
            end
            else
            begin
                rsp_next = '{status: ST_EMPTY, slot_index: '0};
            end
        end
        else if (key_hit)
        begin
            if (op_reg == OP_INSERT)
            begin
                rsp_next = '{status: ST_DUPLICATE, slot_index: '0};
            end
            else
            begin
                rsp_next = '{status: ST_FOUND, slot_index: SLOT_W'(idx_reg)};
            end
        end
        else if (at_last)
        begin
            rsp_next = '{status: ST_END, slot_index: '0};
        end
        else
        begin
            finish = 1'b0;
        end
        if (!cmd.probe)
        begin
            finish     = 1'b0;
            write_slot = 1'b0;
            rsp_next   = rsp_reg;
        end
        done_next = finish;
    end

    // Read the next slot while the current one is compared.
    always_comb
    begin
        idx_next = idx_reg;
        rd_addr  = idx_reg + 1'b1;
        rd_en    = 1'b0;
        if (cmd.fetch)
        begin
            idx_next = home;
            rd_addr  = home;
            rd_en    = 1'b1;
        end
        else if (cmd.probe && !finish)
        begin
            idx_next = idx_reg + 1'b1;
            rd_en    = 1'b1;
        end
    end

    assign wr_en   = cmd.clr || write_slot;
    assign wr_addr = cmd.clr ? clr_reg : idx_reg;
    assign wr_data = cmd.clr ? '0 : {1'b1, key_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.opcode;
            key_reg <= req.key;
        end
        idx_reg <= idx_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            done_reg <= done_next;
        end
    end

    assign sts.clr_done   = (clr_reg == LAST_IDX);
    assign sts.hash_done  = hash_last;
    assign sts.probe_done = finish;

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> sv/lpht_ctrl.sv
// Controller: sequences the clearing pass, then hashing and probing of each item.
module lpht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lpht_pkg::dp_sts_t sts,
    output lpht_pkg::dp_cmd_t cmd,
    output logic              busy
);
    import lpht_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (sts.hash_done)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (sts.probe_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
            end
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_HASH:
            begin
                cmd.hash = 1'b1;
            end
            S_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            S_PROBE:
            begin
                cmd.probe = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/linear_probe_hash_table.sv
// Top level of the linear probing hash table: controller plus datapath.
//
//  channel   ports               handshake
//  --------  ------------------  ------------------------------------------
//  item in   req (req_t)         taken at a clock edge with start & !busy
//  result    rsp (rsp_t)         valid for one cycle while done is high
//
// An item with p slot probes (1 <= p <= TABLE_SIZE - home) passes through
// the home slot (key modulo TABLE_SIZE by a rounded-up reciprocal multiply),
// one memory read set-up, then one slot compared per cycle against the
// registered read port, up to the done cycle. A new item is taken in the
// cycle that carries done. After reset a clearing pass empties every slot,
// with busy high. The receiver cannot stall results.
module linear_probe_hash_table #(
    parameter int TABLE_SIZE = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  lpht_pkg::req_t req,
    output logic           busy,
    output logic           done,
    output lpht_pkg::rsp_t rsp
);
    import lpht_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    lpht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    lpht_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .sts   (sts),
        .done  (done),
        .rsp   (rsp)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after taking an item");

    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without an item in progress");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_INSERTED && rsp.status != ST_FOUND)
            |-> (rsp.slot_index == '0))
        else $error("slot index not zero on a miss, duplicate or end");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the linear probing hash table: directed rows, then random items.
module tb_top;
    import lpht_pkg::*;

    localparam int TABLE_SIZE   = 16;
    localparam int PHASE_ITEMS  = 478;
    localparam int DRAIN_CYCLES = 10 + TABLE_SIZE + 4;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int N_DIR        = 20;

    typedef struct packed
    {
        req_t item;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    // Rows with typed set carry a result read straight off the table contents.
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{req_t'{OP_SEARCH, 31'h0000_0000}, 1'b1, rsp_t'{ST_EMPTY,     4'd0}},
        '{req_t'{OP_SEARCH, 31'h7FFF_FFFF}, 1'b1, rsp_t'{ST_EMPTY,     4'd0}},
        '{req_t'{OP_INSERT, 31'h7FFF_FFFF}, 1'b1, rsp_t'{ST_INSERTED,  4'd15}},
        '{req_t'{OP_INSERT, 31'h7FFF_FFFF}, 1'b1, rsp_t'{ST_DUPLICATE, 4'd0}},
        '{req_t'{OP_INSERT, 31'd31},        1'b1, rsp_t'{ST_END,       4'd0}},
        '{req_t'{OP_SEARCH, 31'd31},        1'b1, rsp_t'{ST_END,       4'd0}},
        '{req_t'{OP_SEARCH, 31'h7FFF_FFFF}, 1'b1, rsp_t'{ST_FOUND,     4'd15}},
        '{req_t'{OP_INSERT, 31'h0000_0000}, 1'b1, rsp_t'{ST_INSERTED,  4'd0}},
        '{req_t'{OP_INSERT, 31'd16},        1'b0, rsp_t'{ST_INSERTED,  4'd0}},
        '{req_t'{OP_INSERT, 31'd32},        1'b0, rsp_t'{ST_INSERTED,  4'd0}},
        '{req_t'{OP_SEARCH, 31'd32},        1'b0, rsp_t'{ST_INSERTED,  4'd0}},
        '{req_t'{OP_SEARCH, 31'd48},        1'b0, rsp_t'{ST_INSERTED,  4'd0}},
        '{req_t'{OP_INSERT, 31'h7FFF_FFF0}, 1'b0, rsp_t'{ST_INSERTED,  4'd0}},
        '{req_t'{OP_SEARCH, 31'h7FFF_FFF0}, 1'b0, rsp_t'{ST_INSERTED,  4'd0}},
        '{req_t'{OP_INSERT, 31'h2AAA_AAAA}, 1'b0, rsp_t'{ST_INSERTED,  4'd0}},
        '{req_t'{OP_INSERT, 31'h5555_5555}, 1'b0, rsp_t'{ST_INSERTED,  4'd0}},
        '{req_t'{OP_SEARCH, 31'h2AAA_AAAA}, 1'b0, rsp_t'{ST_INSERTED,  4'd0}},
        '{req_t'{OP_INSERT, 31'd14},        1'b0, rsp_t'{ST_INSERTED,  4'd0}},
        '{req_t'{OP_INSERT, 31'd30},        1'b0, rsp_t'{ST_INSERTED,  4'd0}},
        '{req_t'{OP_SEARCH, 31'd46},        1'b0, rsp_t'{ST_INSERTED,  4'd0}}
    };

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    logic [KEY_W-1:0] tbl_key  [TABLE_SIZE];
    logic             tbl_used [TABLE_SIZE];
    rsp_t             pending_rsp [$];
    logic [KEY_W-1:0] stored_keys [$];
    rsp_t             want_rsp;
    int               err_cnt = 0;

    linear_probe_hash_table #(
        .TABLE_SIZE (TABLE_SIZE)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Probe upward from the home slot without wrapping; update the table copy on insert.
    function automatic rsp_t probe_table(input req_t item);
        rsp_t res;
        int   idx;
        res.status     = ST_END;
        res.slot_index = '0;
        idx = int'(item.key % TABLE_SIZE);
        while (idx < TABLE_SIZE)
        begin
            if (!tbl_used[idx])
            begin
                if (item.opcode == OP_INSERT)
                begin
                    tbl_key[idx]   = item.key;
                    tbl_used[idx]  = 1'b1;
                    res.status     = ST_INSERTED;
                    res.slot_index = SLOT_W'(idx);
                end
                else
                begin
                    res.status = ST_EMPTY;
                end
                return res;
            end
            if (tbl_key[idx] == item.key)
            begin
                if (item.opcode == OP_INSERT)
                begin
                    res.status = ST_DUPLICATE;
                end
                else
                begin
                    res.status     = ST_FOUND;
                    res.slot_index = SLOT_W'(idx);
                end
                return res;
            end
            idx++;
        end
        return res;
    endfunction

    // Mix stored keys (hits, duplicates), small colliding keys and full-width keys.
    function automatic req_t make_item();
        req_t item;
        int   sel;
        item.opcode = ($urandom_range(1) == 1) ? OP_SEARCH : OP_INSERT;
        sel = $urandom_range(99);
        if (sel < 40 && stored_keys.size() > 0)
            item.key = stored_keys[$urandom_range(stored_keys.size() - 1)];
        else if (sel < 70)
            item.key = KEY_W'($urandom_range(4 * TABLE_SIZE - 1));
        else
            item.key = KEY_W'($urandom);
        return item;
    endfunction

    task automatic send_item(input req_t item, input bit typed, input rsp_t want,
                             input int idle_pct);
        rsp_t model;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        start <= 1'b1;
        req   <= item;
        // Hold the item until an edge sees busy low.
        do
            @(posedge clk);
        while (busy);
        model = probe_table(item);
        pending_rsp.push_back(typed ? want : model);
        if (model.status == ST_INSERTED)
            stored_keys.push_back(item.key);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: result with none expected: status=%0d slot_index=%0d",
                         $time, rsp.status, rsp.slot_index);
                err_cnt++;
            end
            else
            begin
                want_rsp = pending_rsp.pop_front();
                if (rsp.status !== want_rsp.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want_rsp.status, rsp.status);
                    err_cnt++;
                end
                if (rsp.slot_index !== want_rsp.slot_index)
                begin
                    $display("%0t: slot_index mismatch: expected %0d, actual %0d",
                             $time, want_rsp.slot_index, rsp.slot_index);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        int phase_idle [3];
        int wait_cnt;
        phase_idle = '{30, 51, 0};
        wait_cnt   = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            tbl_key[i]  = '0;
            tbl_used[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIR; r++)
            send_item(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].want, phase_idle[0]);

        for (int p = 0; p < 3; p++)
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(make_item(), 1'b0, rsp_t'{ST_INSERTED, 4'd0}, phase_idle[p]);
        start <= 1'b0;

        while (pending_rsp.size() != 0 && wait_cnt < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_rsp.size() != 0)
        begin
            $display("%0t: %0d results never arrived, oldest expected status=%0d slot_index=%0d",
                     $time, pending_rsp.size(), pending_rsp[0].status,
                     pending_rsp[0].slot_index);
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
